[sv/rtr_pkg.sv]
package rtr_pkg;

   localparam int MAX_WIDTH_DEFAULT = 64;
   localparam logic signed [15:0] END_MARK = 16'sd32767;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BBOX_LEFT   = 3'd0,
      CSR_BBOX_TOP    = 3'd1,
      CSR_BBOX_RIGHT  = 3'd2,
      CSR_BBOX_BOTTOM = 3'd3,
      CSR_PLAIN_RECT  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_LINE,
      PHASE_RUN_START,
      PHASE_RUN_END,
      PHASE_DONE
   } phase_type;

   typedef struct packed {
      logic               command;
      logic signed [15:0] data_word;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [15:0]        rect_width;
      logic [15:0]        rect_height;
      logic               is_rect;
      logic               last;
      logic               region_end;
      logic               too_wide;
   } rsp_payload_type;

endpackage

[sv/rtr_ram.sv]
module rtr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/region_to_rectangles_unit.sv]
// channel   ports                          payload            accepted when
// -------   ----------------------------   ----------------   --------------------
// request   req_valid req_stall req_payload  req_payload_type   req_valid & !req_stall
// response  rsp_valid rsp_stall rsp_payload  rsp_payload_type   rsp_valid & !rsp_stall
// csr       csr_write csr_index csr_data     bbox and plain     csr_write
//
// One transaction in flight. Data words are decoded and answered; a plain begin answers with
// the box, a too-wide begin with a status, and any other begin first sets each box column in
// the column-top RAM. A run (x2 word) walks its columns, closing a rectangle still open at
// its end; an empty run skips the walk. The walk is bound by the RAM write port.
// Reset is synchronous; no clearing pass, column tops are set by each begin.
// With rsp_stall high, a full response register holds the walk when a pending rectangle must enter it.
module region_to_rectangles_unit
   import rtr_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  req_payload_type             req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rsp_payload_type             rsp_payload,
   input  logic                        csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WIDTH);
   localparam logic signed [16:0] MAX_S = 17'(MAX_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_SETUP,
      ST_WALK,
      ST_CLOSE,
      ST_FINAL
   } state_type;

   state_type          state_ff;
   logic signed [15:0] left_ff, top_ff, right_ff, bottom_ff;
   logic               plain_ff;
   phase_type          phase_ff;
   logic               overflow_ff;
   logic signed [15:0] line_ff;
   logic signed [15:0] run_start_ff;
   logic               cmd_ff;
   logic signed [15:0] word_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      hi_ff;
   logic               close_ff;
   logic signed [15:0] ctop_ff;
   logic [CW-1:0]      bx_ff;
   logic               pend_v_ff;
   rsp_payload_type    pend_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   logic               out_free;
   logic signed [16:0] box_width;
   logic signed [16:0] run_lo_d;
   logic signed [16:0] run_hi_d;
   logic [CW-1:0]      run_lo;
   logic [CW-1:0]      run_hi;
   logic [CW-1:0]      idx_inc;
   logic signed [15:0] rd_top;
   logic               merge;
   logic               rect_done;
   logic               blocked;
   logic               rsp_load;
   rsp_payload_type    new_rect;
   rsp_payload_type    status;
   rsp_payload_type    box_rect;
   rsp_payload_type    pend_last;

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [15:0]        mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic [15:0]        mem_rd_data;

   function automatic logic [CW-1:0] clamp_col(logic signed [16:0] d);
      logic [CW-1:0] r;
      if (d < 0) begin
         r = '0;
      end else if (d > MAX_S) begin
         r = MAX_CNT;
      end else begin
         r = d[CW-1:0];
      end
      return r;
   endfunction

   rtr_ram #(
      .WIDTH (16),
      .DEPTH (MAX_WIDTH)
   ) u_column_top (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      box_width = {right_ff[15], right_ff} - {left_ff[15], left_ff};
      run_lo_d  = {run_start_ff[15], run_start_ff} - {left_ff[15], left_ff};
      run_hi_d  = {word_ff[15], word_ff} - {left_ff[15], left_ff};
      run_lo    = clamp_col(run_lo_d);
      run_hi    = clamp_col(run_hi_d);
      idx_inc   = idx_ff + 1'b1;
      rd_top    = mem_rd_data;
      merge     = close_ff && (rd_top == ctop_ff);
      rect_done = ((state_ff == ST_WALK) && close_ff && !merge) ||
                  ((state_ff == ST_CLOSE) && close_ff);
      blocked   = rect_done && pend_v_ff && !out_free;

      new_rect             = '0;
      new_rect.rect_x      = left_ff + 16'(bx_ff);
      new_rect.rect_y      = ctop_ff;
      new_rect.rect_width  = 16'(idx_ff - bx_ff);
      new_rect.rect_height = line_ff - ctop_ff;
      new_rect.is_rect     = 1'b1;

      pend_last      = pend_ff;
      pend_last.last = 1'b1;

      status            = '0;
      status.last       = 1'b1;
      status.region_end = (phase_ff == PHASE_DONE);
      status.too_wide   = overflow_ff;

      box_rect             = '0;
      box_rect.rect_x      = left_ff;
      box_rect.rect_y      = top_ff;
      box_rect.rect_width  = 16'(right_ff - left_ff);
      box_rect.rect_height = 16'(bottom_ff - top_ff);
      box_rect.is_rect     = 1'b1;
      box_rect.last        = 1'b1;
      box_rect.region_end  = 1'b1;

      rsp_load    = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = END_MARK;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_inc[AW-1:0];
      case (state_ff)
         ST_DECODE: begin
            rsp_load = (cmd_ff == CMD_BEGIN) && plain_ff && out_free;
         end
         ST_FILL: begin
            mem_wr_en = (idx_ff != hi_ff);
         end
         ST_SETUP: begin
            mem_rd_en   = (run_lo < run_hi);
            mem_rd_addr = run_lo[AW-1:0];
         end
         ST_WALK: begin
            mem_wr_en   = !blocked;
            mem_wr_data = (merge || (rd_top < line_ff)) ? END_MARK : line_ff;
            mem_rd_en   = !blocked && (idx_inc != hi_ff);
            rsp_load    = rect_done && !blocked && pend_v_ff;
         end
         ST_CLOSE: begin
            rsp_load = close_ff && !blocked && pend_v_ff;
         end
         ST_FINAL: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_ff      <= '0;
         top_ff       <= '0;
         right_ff     <= '0;
         bottom_ff    <= '0;
         plain_ff     <= 1'b0;
         phase_ff     <= PHASE_LINE;
         overflow_ff  <= 1'b0;
         line_ff      <= '0;
         run_start_ff <= '0;
         close_ff     <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BBOX_LEFT:   left_ff   <= csr_data;
               CSR_BBOX_TOP:    top_ff    <= csr_data;
               CSR_BBOX_RIGHT:  right_ff  <= csr_data;
               CSR_BBOX_BOTTOM: bottom_ff <= csr_data;
               CSR_PLAIN_RECT:  plain_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_payload.command;
                  word_ff  <= req_payload.data_word;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               pend_v_ff <= 1'b0;
               close_ff  <= 1'b0;
               if (cmd_ff == CMD_BEGIN) begin
                  if (plain_ff) begin
                     if (out_free) begin
                        overflow_ff  <= 1'b0;
                        phase_ff     <= PHASE_DONE;
                        rsp_ff       <= box_rect;
                        state_ff     <= ST_IDLE;
                     end
                  end else begin
                     phase_ff <= PHASE_LINE;
                     if (box_width > MAX_S) begin
                        overflow_ff <= 1'b1;
                        state_ff    <= ST_FINAL;
                     end else begin
                        overflow_ff <= 1'b0;
                        idx_ff      <= '0;
                        hi_ff       <= clamp_col(box_width);
                        state_ff    <= ST_FILL;
                     end
                  end
               end else if (overflow_ff) begin
                  state_ff <= ST_FINAL;
               end else begin
                  state_ff <= ST_FINAL;
                  case (phase_ff)
                     PHASE_LINE: begin
                        if (word_ff == END_MARK) begin
                           phase_ff <= PHASE_DONE;
                        end else begin
                           line_ff  <= word_ff;
                           phase_ff <= PHASE_RUN_START;
                        end
                     end
                     PHASE_RUN_START: begin
                        if (word_ff == END_MARK) begin
                           phase_ff <= PHASE_LINE;
                        end else begin
                           run_start_ff <= word_ff;
                           phase_ff     <= PHASE_RUN_END;
                        end
                     end
                     PHASE_RUN_END: begin
                        phase_ff <= PHASE_RUN_START;
                        state_ff <= ST_SETUP;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_FILL: begin
               if (idx_ff == hi_ff) begin
                  state_ff <= ST_FINAL;
               end else begin
                  idx_ff <= idx_inc;
               end
            end
            ST_SETUP: begin
               idx_ff <= run_lo;
               hi_ff  <= run_hi;
               if (run_lo < run_hi) begin
                  state_ff <= ST_WALK;
               end else begin
                  state_ff <= ST_FINAL;
               end
            end
            ST_WALK: begin
               if (!blocked) begin
                  if (rect_done) begin
                     if (pend_v_ff) begin
                        rsp_ff <= pend_ff;
                     end
                     pend_ff   <= new_rect;
                     pend_v_ff <= 1'b1;
                  end
                  if (!merge) begin
                     if (rd_top < line_ff) begin
                        close_ff <= 1'b1;
                        ctop_ff  <= rd_top;
                        bx_ff    <= idx_ff;
                     end else begin
                        close_ff <= 1'b0;
                     end
                  end
                  idx_ff <= idx_inc;
                  if (idx_inc == hi_ff) begin
                     state_ff <= ST_CLOSE;
                  end
               end
            end
            ST_CLOSE: begin
               if (!close_ff) begin
                  state_ff <= ST_FINAL;
               end else if (!blocked) begin
                  if (pend_v_ff) begin
                     rsp_ff <= pend_ff;
                  end
                  pend_ff   <= new_rect;
                  pend_v_ff <= 1'b1;
                  close_ff  <= 1'b0;
               end
            end
            ST_FINAL: begin
               if (out_free) begin
                  if (pend_v_ff) begin
                     rsp_ff <= pend_last;
                  end else begin
                     rsp_ff <= status;
                  end
                  pend_v_ff <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DECODE)
      else $error("accepted transaction not decoded");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff && !close_ff)
      else $error("rectangle left pending at idle");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> idx_ff < hi_ff)
      else $error("walk column out of run");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> idx_ff <= hi_ff)
      else $error("fill index past column count");

endmodule

[tb/sv/tb_region_to_rectangles_unit.sv]
`timescale 1ns / 100ps

module tb_region_to_rectangles_unit;
   import rtr_pkg::*;

   localparam int MAX_W = MAX_WIDTH_DEFAULT;
   localparam int LIMIT_CYCLES = 600000;
   localparam int RANDOM_ITEMS = 120;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_PREDICTED,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      csr_index_type   idx;
      logic [15:0]     value;
      req_payload_type req;
      rsp_payload_type typed;
   } dir_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_payload_type            req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // predictor state
   logic signed [15:0] bbox_left_q, bbox_top_q, bbox_right_q, bbox_bottom_q;
   logic               plain_q;
   logic signed [15:0] col_top_m [MAX_W];
   phase_type          phase_m;
   logic signed [15:0] line_m, run_start_m;
   logic               wide_m;

   rsp_payload_type expected_rects[$];
   dir_row_type     directed_rows[$];
   rsp_payload_type wanted;
   int              error_count = 0;
   int              cycle_count = 0;
   bit              quiet = 1'b0;

   region_to_rectangles_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_rects.size());
         $display("tb_region_to_rectangles_unit failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = !quiet && ($urandom_range(99) < 24);
   end

   function automatic rsp_payload_type make_rect(int x, int y, int w, int h, logic is_r,
                                                 logic lst, logic re, logic tw);
      rsp_payload_type r;
      r.rect_x      = 16'(x);
      r.rect_y      = 16'(y);
      r.rect_width  = 16'(w);
      r.rect_height = 16'(h);
      r.is_rect     = is_r;
      r.last        = lst;
      r.region_end  = re;
      r.too_wide    = tw;
      return r;
   endfunction

   function automatic void add_write(csr_index_type idx, logic [15:0] value);
      dir_row_type row;
      row = '0;
      row.kind  = ROW_WRITE;
      row.idx   = idx;
      row.value = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(logic cmd, logic [15:0] word, bit typed,
                                    rsp_payload_type r);
      dir_row_type row;
      row = '0;
      row.kind           = typed ? ROW_TYPED : ROW_PREDICTED;
      row.req.command    = cmd;
      row.req.data_word  = word;
      row.typed          = r;
      directed_rows.push_back(row);
   endfunction

   task automatic predict_rectangles(input req_payload_type p);
      int     l, t, width, lo, hi, x, bx, top, y, i, n;
      n = 0;
      if (p.command == CMD_BEGIN) begin
         l = bbox_left_q;
         t = bbox_top_q;
         width = int'(bbox_right_q) - l;
         if (plain_q) begin
            wide_m  = 1'b0;
            phase_m = PHASE_DONE;
            expected_rects.push_back(make_rect(l, t, width, int'(bbox_bottom_q) - t,
                                               1'b1, 1'b1, 1'b1, 1'b0));
            return;
         end
         phase_m = PHASE_LINE;
         if (width > MAX_W) begin
            wide_m = 1'b1;
         end else begin
            wide_m = 1'b0;
            for (i = 0; i < width; i++) col_top_m[i] = END_MARK;
         end
      end else if (!wide_m) begin
         case (phase_m)
            PHASE_LINE: begin
               if (p.data_word == END_MARK) begin
                  phase_m = PHASE_DONE;
               end else begin
                  line_m  = p.data_word;
                  phase_m = PHASE_RUN_START;
               end
            end
            PHASE_RUN_START: begin
               if (p.data_word == END_MARK) begin
                  phase_m = PHASE_LINE;
               end else begin
                  run_start_m = p.data_word;
                  phase_m     = PHASE_RUN_END;
               end
            end
            PHASE_RUN_END: begin
               phase_m = PHASE_RUN_START;
               l  = bbox_left_q;
               y  = line_m;
               lo = (int'(run_start_m) > l) ? int'(run_start_m) : l;
               hi = (int'(p.data_word) < l + MAX_W) ? int'(p.data_word) : l + MAX_W;
               x  = lo;
               while (x < hi) begin
                  top = col_top_m[x - l];
                  if (top < y) begin
                     bx = x;
                     while (x < hi && int'(col_top_m[x - l]) == top) begin
                        col_top_m[x - l] = END_MARK;
                        x++;
                     end
                     if (n < MAX_W) begin
                        expected_rects.push_back(make_rect(bx, top, x - bx, y - top,
                                                           1'b1, 1'b0, 1'b0, 1'b0));
                        n++;
                     end
                  end else begin
                     col_top_m[x - l] = 16'(y);
                     x++;
                  end
               end
            end
            default: ;
         endcase
      end
      if (n == 0) begin
         expected_rects.push_back(make_rect(0, 0, 0, 0, 1'b0, 1'b1,
                                            phase_m == PHASE_DONE, wide_m));
      end else begin
         expected_rects[expected_rects.size() - 1].last = 1'b1;
      end
   endtask

   task automatic send_request(input req_payload_type p, input bit typed,
                               input rsp_payload_type typed_r);
      rsp_payload_type scratch;
      while (!quiet && $urandom_range(99) < 24) @(negedge clock);
      req_payload = p;
      req_valid   = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_rectangles(p);
      if (typed) begin
         scratch = expected_rects.pop_back();
         expected_rects.push_back(typed_r);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      while (expected_rects.size() != 0) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value;
      case (idx)
         CSR_BBOX_LEFT:   bbox_left_q   = value;
         CSR_BBOX_TOP:    bbox_top_q    = value;
         CSR_BBOX_RIGHT:  bbox_right_q  = value;
         CSR_BBOX_BOTTOM: bbox_bottom_q = value;
         CSR_PLAIN_RECT:  plain_q       = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rects.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result x=%0d y=%0d w=%0d h=%0d r=%0b l=%0b e=%0b o=%0b",
                        rsp_payload.rect_x, rsp_payload.rect_y, rsp_payload.rect_width,
                        rsp_payload.rect_height, rsp_payload.is_rect, rsp_payload.last,
                        rsp_payload.region_end, rsp_payload.too_wide);
         end else begin
            wanted = expected_rects.pop_front();
            if (rsp_payload !== wanted) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch exp x=%0d y=%0d w=%0d h=%0d r=%0b l=%0b e=%0b o=%0b",
                            " got x=%0d y=%0d w=%0d h=%0d r=%0b l=%0b e=%0b o=%0b"},
                           wanted.rect_x, wanted.rect_y, wanted.rect_width,
                           wanted.rect_height, wanted.is_rect, wanted.last,
                           wanted.region_end, wanted.too_wide,
                           rsp_payload.rect_x, rsp_payload.rect_y, rsp_payload.rect_width,
                           rsp_payload.rect_height, rsp_payload.is_rect, rsp_payload.last,
                           rsp_payload.region_end, rsp_payload.too_wide);
            end
         end
      end
   end

   initial begin
      dir_row_type     row;
      req_payload_type region_items[$];
      req_payload_type p;
      rsp_payload_type idle_status, none;
      int              left, width, r, y, x1, x2, lines, runs, region_index, random_items;
      int              ln, rn, k2;

      bbox_left_q   = '0;
      bbox_top_q    = '0;
      bbox_right_q  = '0;
      bbox_bottom_q = '0;
      plain_q       = 1'b0;
      phase_m       = PHASE_LINE;
      line_m        = '0;
      run_start_m   = '0;
      wide_m        = 1'b0;
      foreach (col_top_m[i]) col_top_m[i] = '0;
      none        = '0;
      idle_status = make_rect(0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);

      // directed transactions
      add_item(CMD_DATA, 16'd100, 1'b1, idle_status);
      add_write(CSR_BBOX_LEFT, 16'd0);
      add_write(CSR_BBOX_TOP, 16'd0);
      add_write(CSR_BBOX_RIGHT, 16'd64);
      add_write(CSR_BBOX_BOTTOM, 16'd50);
      add_write(CSR_PLAIN_RECT, 16'd0);
      add_item(CMD_BEGIN, 16'd0, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd10, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd0, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd64, 1'b1, idle_status);
      add_item(CMD_DATA, END_MARK, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd20, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd5, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd9, 1'b0, none);
      add_item(CMD_DATA, 16'h8000, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd3, 1'b0, none);
      add_item(CMD_DATA, 16'd60, 1'b1, idle_status);
      add_item(CMD_DATA, END_MARK, 1'b0, none);
      add_item(CMD_DATA, 16'd40, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd30, 1'b0, none);
      add_item(CMD_DATA, END_MARK, 1'b1, idle_status);
      add_item(CMD_DATA, END_MARK, 1'b1, make_rect(0, 0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0));
      add_item(CMD_DATA, 16'd1234, 1'b1, make_rect(0, 0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0));
      add_write(CSR_BBOX_LEFT, 16'h8000);
      add_write(CSR_BBOX_RIGHT, 16'h7fff);
      add_item(CMD_BEGIN, 16'd0, 1'b1, make_rect(0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b1));
      add_item(CMD_DATA, 16'hffff, 1'b1, make_rect(0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b1));
      add_write(CSR_BBOX_TOP, 16'h8000);
      add_write(CSR_BBOX_BOTTOM, 16'h7fff);
      add_write(CSR_PLAIN_RECT, 16'd1);
      add_item(CMD_BEGIN, 16'hffff, 1'b1,
               make_rect(-32768, -32768, 65535, 65535, 1'b1, 1'b1, 1'b1, 1'b0));
      add_item(CMD_DATA, 16'd0, 1'b1, make_rect(0, 0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0));
      add_write(CSR_PLAIN_RECT, 16'd0);
      add_write(CSR_BBOX_LEFT, 16'd10);
      add_write(CSR_BBOX_RIGHT, 16'd5);
      add_item(CMD_BEGIN, 16'd0, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd40, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd12, 1'b1, idle_status);
      add_item(CMD_DATA, 16'd20, 1'b0, none);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         case (row.kind)
            ROW_WRITE:     write_register(row.idx, row.value);
            ROW_PREDICTED: send_request(row.req, 1'b0, none);
            default:       send_request(row.req, 1'b1, row.typed);
         endcase
      end

      // random regions, mostly well formed
      random_items = 0;
      region_index = 0;
      while (random_items < RANDOM_ITEMS) begin
         quiet = (region_index >= 2 && region_index < 5);
         r = $urandom_range(99);
         if ($urandom_range(19) == 0) left = $urandom_range(65535);
         else left = int'($urandom_range(255)) - 128;
         if (r < 8) width = 65 + $urandom_range(2000);
         else if (r < 14) width = -int'($urandom_range(20));
         else if (r < 24) width = MAX_W;
         else width = $urandom_range(40, 1);
         write_register(CSR_BBOX_LEFT, 16'(left));
         write_register(CSR_BBOX_TOP, 16'($urandom));
         write_register(CSR_BBOX_RIGHT, 16'(left + width));
         write_register(CSR_BBOX_BOTTOM, 16'($urandom));
         write_register(CSR_PLAIN_RECT, 16'($urandom_range(9) == 0));
         left  = bbox_left_q;
         width = int'(bbox_right_q) - left;

         region_items.delete();
         p.command   = CMD_BEGIN;
         p.data_word = 16'($urandom);
         region_items.push_back(p);
         if (plain_q || width > MAX_W) begin
            for (k2 = 0; k2 < int'($urandom_range(3, 1)); k2++) begin
               p.command   = CMD_DATA;
               p.data_word = 16'($urandom);
               region_items.push_back(p);
            end
         end else begin
            if (width < 1) width = 16;
            lines = $urandom_range(6, 1);
            y = int'($urandom_range(60000)) - 30000;
            for (ln = 0; ln < lines; ln++) begin
               y += $urandom_range(30, 1);
               p.command   = CMD_DATA;
               p.data_word = 16'(y);
               region_items.push_back(p);
               runs = $urandom_range(4);
               for (rn = 0; rn < runs; rn++) begin
                  x1 = left + int'($urandom_range(width + 8)) - 4;
                  if ($urandom_range(9) == 0) x2 = x1 - int'($urandom_range(5));
                  else x2 = x1 + int'($urandom_range(12));
                  p.data_word = 16'(x1);
                  region_items.push_back(p);
                  p.data_word = 16'(x2);
                  region_items.push_back(p);
               end
               if ($urandom_range(19) == 0) begin
                  p.data_word = 16'($urandom);
                  region_items.push_back(p);
               end
               if ($urandom_range(24) == 0) begin
                  p.command   = CMD_BEGIN;
                  p.data_word = 16'($urandom);
                  region_items.push_back(p);
                  p.command   = CMD_DATA;
               end
               p.data_word = END_MARK;
               region_items.push_back(p);
            end
            if ($urandom_range(6) != 0) begin
               p.data_word = END_MARK;
               region_items.push_back(p);
               if ($urandom_range(3) == 0) begin
                  p.data_word = 16'($urandom);
                  region_items.push_back(p);
               end
            end
         end
         random_items += region_items.size();
         foreach (region_items[k]) send_request(region_items[k], 1'b0, none);
         region_index++;
      end
      quiet = 1'b0;

      while (expected_rects.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_rects.size() == 0) begin
         $display("tb_region_to_rectangles_unit passed");
      end else begin
         $display("tb_region_to_rectangles_unit failed");
      end
      $finish;
   end

endmodule
